// File: src/mbrs_pkg.sv
// ----------------------------------------------------------------------------
// Modbus RTU register slave package
// Shared constants, codes and the CRC-16 byte step.
// ----------------------------------------------------------------------------
package mbrs_pkg;

  localparam int FRAME_MAX_DEF = 32;
  localparam int NUM_REGS_DEF  = 5;
  localparam int MAX_READ      = 13;
  localparam int RSP_MAX       = 32;

  localparam logic [7:0] FN_READ      = 8'h03;
  localparam logic [7:0] FN_WRITE     = 8'h06;
  localparam logic [7:0] FN_READ_EXC  = 8'h83;
  localparam logic [7:0] FN_WRITE_EXC = 8'h86;
  localparam logic [7:0] EXC_FLAG     = 8'h80;
  localparam logic [7:0] EXC_FUNC     = 8'h01;
  localparam logic [7:0] EXC_ADDR     = 8'h02;
  localparam logic [7:0] MIN_FRAME    = 8'h04;

  localparam logic CMD_BYTE = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  localparam logic [0:0] REG_STATION = 1'b0;
  localparam logic [0:0] REG_IDLE    = 1'b1;

  // Datapath operations requested by the controller.
  typedef enum logic [2:0] {
    OP_NONE, OP_CRC_RX, OP_LOAD_F, OP_BUILD, OP_CRC_TX, OP_SEND
  } dp_op_t;

  typedef struct packed {
    dp_op_t     op;
    logic [6:0] idx;
  } dp_cmd_t;

  typedef struct packed {
    logic       frame_ok;
    logic [5:0] rsp_len;
  } dp_sts_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] c_in, input logic [7:0] d);
    logic [15:0] c;
    c = c_in ^ {8'h00, d};
    for (int b = 0; b < 8; b++) begin
      c = c[0] ? ((c >> 1) ^ 16'hA001) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// File: src/mbrs_datapath.sv
// ----------------------------------------------------------------------------
// Modbus RTU register slave datapath
// Frame store, registers, CRC unit and response buffer.
// ----------------------------------------------------------------------------
module mbrs_datapath #(
  parameter int FRAME_MAX = mbrs_pkg::FRAME_MAX_DEF,
  parameter int NUM_REGS  = mbrs_pkg::NUM_REGS_DEF,
  localparam int CW = $clog2(FRAME_MAX + 1),
  localparam int AW = $clog2(FRAME_MAX)
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               wr_en,
  input  logic [CW-1:0]      wr_ptr,
  input  logic [7:0]         wr_data,
  input  logic [CW-1:0]      n_bytes,
  input  logic [7:0]         station,
  input  mbrs_pkg::dp_cmd_t  cmd,
  output mbrs_pkg::dp_sts_t  sts,
  output logic [7:0]         tx_byte,
  output logic               buzzer
);

  logic [7:0]  mem [FRAME_MAX];
  logic [7:0]  rd_q;
  logic [15:0] crc_r;
  logic [7:0]  f_r [6];
  logic [7:0]  rsp_r [mbrs_pkg::RSP_MAX];
  logic [5:0]  len_r;
  logic [7:0]  regs_r [NUM_REGS];
  logic        buzz_r;
  logic        ok_r;

  // Frame store: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr[AW-1:0]] <= wr_data;
    end
    rd_q <= mem[cmd.idx[AW-1:0]];
  end

  logic [15:0] start_w, qty_w, addr_w;
  assign start_w = {f_r[2], f_r[3]};
  assign qty_w   = {f_r[4], f_r[5]};
  assign addr_w  = start_w;

  function automatic logic [7:0] rd_reg(input logic [15:0] a, input logic [7:0] r [NUM_REGS],
                                        input logic bz);
    logic [7:0] v;
    v = {7'd0, bz};
    for (int i = 0; i < NUM_REGS; i++) begin
      if (a == 16'(i)) v = r[i];
    end
    return v;
  endfunction

  // prev_idx_r is the byte whose read was issued in the previous cycle (rd_q holds it).
  logic [6:0] prev_idx_r;
  always_ff @(posedge clk) begin
    prev_idx_r <= cmd.idx;
    if (!rst_n) begin
      buzz_r <= 1'b0;
      ok_r   <= 1'b0;
      for (int i = 0; i < NUM_REGS; i++) regs_r[i] <= 8'h00;
    end else begin
      unique case (cmd.op)
        mbrs_pkg::OP_CRC_RX: begin
          // Run over bytes 0..n-3, then compare CRC with the final two.
          if (prev_idx_r == 7'd0) crc_r <= mbrs_pkg::crc_byte(16'hFFFF, rd_q);
          else if (7'(prev_idx_r) < 7'(n_bytes - 2)) crc_r <= mbrs_pkg::crc_byte(crc_r, rd_q);
          if (prev_idx_r == 7'd0) ok_r <= (rd_q == station) && (n_bytes >= CW'(4));
          else if (7'(prev_idx_r) == 7'(n_bytes - 2)) ok_r <= ok_r && (rd_q == crc_r[7:0]);
          else if (7'(prev_idx_r) == 7'(n_bytes - 1)) ok_r <= ok_r && (rd_q == crc_r[15:8]);
          // Field bytes that a short frame never reaches read as zero.
          if (prev_idx_r == 7'd0) begin
            for (int k = 1; k < 6; k++) f_r[k] <= 8'h00;
          end
          if (prev_idx_r < 7'd6) begin
            f_r[prev_idx_r[2:0]] <= (7'(prev_idx_r) < 7'(n_bytes - 2)) ? rd_q : 8'h00;
          end
        end
        mbrs_pkg::OP_BUILD: begin
          if (ok_r) begin
            rsp_r[0] <= f_r[0];
            if (f_r[1] == mbrs_pkg::FN_READ) begin
              if (start_w > 16'(NUM_REGS) || qty_w == 16'd0 || qty_w > 16'(mbrs_pkg::MAX_READ)
                  || (17'(start_w) + 17'(qty_w)) > 17'(NUM_REGS + 1)) begin
                rsp_r[1] <= mbrs_pkg::FN_READ_EXC;
                rsp_r[2] <= mbrs_pkg::EXC_ADDR;
                len_r    <= 6'd3;
              end else begin
                rsp_r[1] <= mbrs_pkg::FN_READ;
                rsp_r[2] <= {qty_w[6:0], 1'b0};
                for (int k = 0; k < mbrs_pkg::MAX_READ; k++) begin
                  rsp_r[3 + 2*k] <= 8'h00;
                  rsp_r[4 + 2*k] <= rd_reg(start_w + 16'(k), regs_r, buzz_r);
                end
                len_r <= 6'(3 + 2 * qty_w[3:0]);
              end
            end else if (f_r[1] == mbrs_pkg::FN_WRITE) begin
              if (addr_w > 16'(NUM_REGS)) begin
                rsp_r[1] <= mbrs_pkg::FN_WRITE_EXC;
                rsp_r[2] <= mbrs_pkg::EXC_ADDR;
                len_r    <= 6'd3;
              end else begin
                for (int i = 0; i < NUM_REGS; i++) begin
                  if (addr_w == 16'(i)) regs_r[i] <= f_r[5];
                end
                if (addr_w == 16'(NUM_REGS)) buzz_r <= (f_r[5] != 8'h00);
                for (int k = 1; k < 6; k++) rsp_r[k] <= f_r[k];
                len_r <= 6'd6;
              end
            end else begin
              rsp_r[1] <= f_r[1] | mbrs_pkg::EXC_FLAG;
              rsp_r[2] <= mbrs_pkg::EXC_FUNC;
              len_r    <= 6'd3;
            end
            crc_r <= 16'hFFFF;
          end
        end
        mbrs_pkg::OP_CRC_TX: begin
          if (cmd.idx < 7'(len_r)) begin
            crc_r <= mbrs_pkg::crc_byte(crc_r, rsp_r[cmd.idx[4:0]]);
          end else begin
            rsp_r[len_r[4:0]]        <= crc_r[7:0];
            rsp_r[5'(len_r + 6'd1)]  <= crc_r[15:8];
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign sts.frame_ok = ok_r;
  assign sts.rsp_len  = len_r + 6'd2;
  assign tx_byte      = rsp_r[cmd.idx[4:0]];
  assign buzzer       = buzz_r;

endmodule

// File: src/mbrs_ctrl.sv
// ----------------------------------------------------------------------------
// Modbus RTU register slave controller
// Input handshake, idle timing and the frame handling sequence.
// ----------------------------------------------------------------------------
module mbrs_ctrl #(
  parameter int FRAME_MAX = mbrs_pkg::FRAME_MAX_DEF,
  localparam int CW = $clog2(FRAME_MAX + 1)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              in_cmd,
  input  logic [7:0]        in_tick_ms,
  input  logic [7:0]        idle_limit,
  input  logic              out_ready,
  output logic              out_valid,
  output logic              out_last,
  output logic              wr_en,
  output logic [CW-1:0]     wr_ptr,
  output logic [CW-1:0]     n_bytes,
  output mbrs_pkg::dp_cmd_t cmd,
  input  mbrs_pkg::dp_sts_t sts
);

  typedef enum logic [2:0] {S_IDLE, S_CRC, S_BUILD, S_TXCRC, S_SEND} state_t;

  state_t      state_r;
  logic [CW-1:0] cnt_r, seen_r;
  logic [7:0]  timer_r;
  logic [6:0]  idx_r;
  logic [8:0]  sum;
  logic [7:0]  tnew;

  assign in_ready  = (state_r == S_IDLE);
  assign wr_en     = in_valid && in_ready && (in_cmd == mbrs_pkg::CMD_BYTE)
                     && (cnt_r < CW'(FRAME_MAX));
  assign wr_ptr    = cnt_r;
  assign n_bytes   = cnt_r;
  assign sum       = 9'(timer_r) + 9'(in_tick_ms);
  assign tnew      = sum[8] ? 8'hFF : sum[7:0];
  assign out_valid = (state_r == S_SEND);
  assign out_last  = (idx_r == 7'(sts.rsp_len - 6'd1));

  always_comb begin
    cmd.idx = idx_r;
    unique case (state_r)
      S_CRC:   cmd.op = mbrs_pkg::OP_CRC_RX;
      S_BUILD: cmd.op = mbrs_pkg::OP_BUILD;
      S_TXCRC: cmd.op = mbrs_pkg::OP_CRC_TX;
      S_SEND:  cmd.op = mbrs_pkg::OP_SEND;
      default: cmd.op = mbrs_pkg::OP_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      seen_r  <= '0;
      timer_r <= 8'd0;
      idx_r   <= 7'd0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          idx_r <= 7'd0;
          if (in_valid) begin
            if (in_cmd == mbrs_pkg::CMD_BYTE) begin
              if (cnt_r < CW'(FRAME_MAX)) cnt_r <= cnt_r + CW'(1);
            end else if (cnt_r == '0) begin
              seen_r  <= '0;
              timer_r <= 8'd0;
            end else if (seen_r != cnt_r) begin
              seen_r  <= cnt_r;
              timer_r <= 8'd0;
            end else if (tnew >= idle_limit) begin
              timer_r <= 8'd0;
              seen_r  <= '0;
              state_r <= S_CRC;
            end else begin
              timer_r <= tnew;
            end
          end
        end
        S_CRC: begin
          // Reads are issued in the cycle before their use.
          idx_r <= idx_r + 7'd1;
          if (idx_r == 7'(cnt_r)) begin
            idx_r <= 7'd0;
            state_r <= (cnt_r >= CW'(4)) ? S_BUILD : S_IDLE;
            if (cnt_r < CW'(4)) cnt_r <= '0;
          end
        end
        S_BUILD: begin
          if (!sts.frame_ok) begin
            cnt_r   <= '0;
            state_r <= S_IDLE;
          end else begin
            state_r <= S_TXCRC;
          end
        end
        S_TXCRC: begin
          idx_r <= idx_r + 7'd1;
          if (idx_r == 7'(sts.rsp_len - 6'd2)) begin
            idx_r   <= 7'd0;
            state_r <= S_SEND;
          end
        end
        S_SEND: begin
          if (out_ready) begin
            idx_r <= idx_r + 7'd1;
            if (out_last) begin
              cnt_r   <= '0;
              state_r <= S_IDLE;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

// File: src/modbus_rtu_register_slave_core.sv
// ----------------------------------------------------------------------------
// Modbus RTU register slave core
// Collects a request frame, checks it and streams back the response.
// ----------------------------------------------------------------------------
// Input items carry either a received byte (cmd 0) or a millisecond tick
// (cmd 1). When a tick finds the byte count unchanged for idle_limit ms,
// the frame is handled: the CRC unit walks the frame store one byte a cycle,
// the response is built, and its CRC is run over each response byte and
// then appended. The response then leaves one byte per item on the output
// channel, the final byte marked by out_last_byte. While a frame is handled
// or its response is sent, in_ready is low; a stalled receiver simply holds
// the block in the sending phase. Frames that fail the address or CRC
// checks give no output.
// Reset clears the counters, holding registers and the buzzer flag, and sets
// station address 1 and idle limit 5. Configuration writes take effect at once;
// the user must make them only while the block is idle, as the block does not enforce it.
// ----------------------------------------------------------------------------
module modbus_rtu_register_slave_core #(
  parameter int FRAME_MAX = mbrs_pkg::FRAME_MAX_DEF,
  parameter int NUM_REGS  = mbrs_pkg::NUM_REGS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       in_cmd,
  input  logic [7:0] in_rx_byte,
  input  logic [7:0] in_tick_ms,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_tx_byte,
  output logic       out_last_byte,
  output logic       out_buzzer_on,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [7:0] cfg_data
);

  localparam int CW = $clog2(FRAME_MAX + 1);

  logic [7:0]        station_r, idle_r;
  logic              wr_en;
  logic [CW-1:0]     wr_ptr, n_bytes;
  mbrs_pkg::dp_cmd_t cmd;
  mbrs_pkg::dp_sts_t sts;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      station_r <= 8'd1;
      idle_r    <= 8'd5;
    end else if (cfg_we) begin
      if (cfg_index == mbrs_pkg::REG_STATION) station_r <= cfg_data;
      else                                     idle_r    <= cfg_data;
    end
  end

  mbrs_ctrl #(.FRAME_MAX(FRAME_MAX)) u_ctrl (
    .clk, .rst_n, .in_valid, .in_ready, .in_cmd, .in_tick_ms,
    .idle_limit(idle_r), .out_ready, .out_valid, .out_last(out_last_byte),
    .wr_en, .wr_ptr, .n_bytes, .cmd, .sts
  );

  mbrs_datapath #(.FRAME_MAX(FRAME_MAX), .NUM_REGS(NUM_REGS)) u_dp (
    .clk, .rst_n, .wr_en, .wr_ptr, .wr_data(in_rx_byte), .n_bytes,
    .station(station_r), .cmd, .sts, .tx_byte(out_tx_byte), .buzzer(out_buzzer_on)
  );

endmodule

// File: src/mbrs_checker.sv
// ----------------------------------------------------------------------------
// Modbus RTU register slave checker
// Port-level properties of the core, attached by bind.
// ----------------------------------------------------------------------------
module mbrs_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic out_last_byte,
  input logic out_buzzer_on
);

  // No new item is taken while a response is being sent.
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready) else $error("input taken during response");

  // The buzzer flag cannot change in the middle of a response.
  a_buzz_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && $past(out_valid) && $past(rst_n)) |-> $stable(out_buzzer_on))
    else $error("buzzer changed mid response");

  // After the final byte leaves, the output falls idle.
  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && out_last_byte) |=> !out_valid)
    else $error("output continued after last byte");

  // A stalled response holds its marker.
  a_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_last_byte)))
    else $error("stalled output changed");

endmodule

bind modbus_rtu_register_slave_core mbrs_checker u_chk (
  .clk, .rst_n, .in_valid, .in_ready, .out_valid, .out_ready, .out_last_byte, .out_buzzer_on
);
